// File: rtl/dnv_pkg.sv
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types and constants for the domain name validator.
// ----------------------------------------------------------------------------
package dnv_pkg;

   localparam logic [7:0] CH_END  = 8'h00;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [6:0]  LABEL_SAT = 7'd127;
   localparam logic [8:0]  NAME_SAT  = 9'd511;
   localparam logic [10:0] RAW_SAT   = 11'd2047;
   localparam logic [9:0]  BYTE_MAX  = 10'd255;

   // Escape sequencer: none, after the backslash, after one digit, after two digits.
   typedef enum logic [3:0] {
      ESC_NONE  = 4'b0001,
      ESC_START = 4'b0010,
      ESC_ONE   = 4'b0100,
      ESC_TWO   = 4'b1000
   } esc_type;

   typedef struct packed {
      logic [6:0]  label_count;
      logic [8:0]  name_count;
      logic [10:0] raw_count;
      esc_type     esc;
      logic [9:0]  decimal_value;
      logic        error_seen;
      logic        first_was_dot;
   } dnv_state_type;

   localparam dnv_state_type DNV_CLEAR = '{
      label_count:   7'd0,
      name_count:    9'd0,
      raw_count:     11'd0,
      esc:           ESC_NONE,
      decimal_value: 10'd0,
      error_seen:    1'b0,
      first_was_dot: 1'b0
   };

endpackage

// File: rtl/domain_name_validator_core.sv
// ----------------------------------------------------------------------------
// domain_name_validator_core
// Checks a text-form domain name fed one character per item.
// ----------------------------------------------------------------------------
// Characters enter one per item on the req_ channel; a zero character ends the
// name and yields one item on the rsp_ channel with rsp_status 0 for a good name
// and 1 for a bad one, after which the checker is clear for the next name.
// Other characters yield no result. The block takes one item per cycle except
// while a terminator waits behind an unread verdict: each character is held in
// an input register while the counter and escape update is applied, and a
// terminator's verdict then moves into the result register. A waiting verdict
// stalls only a following terminator.
module domain_name_validator_core
   import dnv_pkg::*;
#(
   parameter int unsigned MAX_LABEL = 63,
   parameter int unsigned MAX_NAME  = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_char_ff, in_char_in;
   dnv_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff, rsp_status_in;

   dnv_state_type step_nxt;
   logic          step_bad;
   logic          is_term;
   logic          out_free;
   logic          advance;
   logic          req_fire;

   dnv_step #(
      .MAX_LABEL(MAX_LABEL),
      .MAX_NAME (MAX_NAME)
   ) u_step (
      .cur    (state_ff),
      .char_in(in_char_ff),
      .nxt    (step_nxt),
      .bad    (step_bad)
   );

   assign is_term   = (in_char_ff == CH_END);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!is_term || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_char_in    = in_char_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_nxt;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_in;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && is_term) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = step_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= DNV_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff    <= in_char_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // A terminator leaves the checker fully cleared.
   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      advance && is_term |=> (state_ff == DNV_CLEAR))
      else $error("state not cleared after terminator");

   // A new verdict appears only from a processed terminator.
   a_rsp_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && is_term))
      else $error("verdict without terminator");

   // The input stage refuses an item only while it holds a stalled terminator.
   a_stall_only_term: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && is_term && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

endmodule

// File: rtl/dnv_step.sv
// ----------------------------------------------------------------------------
// dnv_step
// Next-state and verdict logic for one character of a domain name.
// ----------------------------------------------------------------------------
module dnv_step
   import dnv_pkg::*;
#(
   parameter int unsigned MAX_LABEL = 63,
   parameter int unsigned MAX_NAME  = 255
) (
   input  dnv_state_type cur,
   input  logic [7:0]    char_in,
   output dnv_state_type nxt,
   output logic          bad
);

   localparam logic [6:0]  LABEL_LIMIT = 7'(MAX_LABEL);
   localparam logic [8:0]  NAME_LIMIT  = 9'(MAX_NAME);
   localparam logic [10:0] RAW_LIMIT   = 11'(4 * MAX_NAME);

   logic        is_digit;
   logic [7:0]  digit_diff;
   logic [3:0]  digit_val;
   logic [6:0]  label_inc;
   logic [8:0]  name_inc;
   logic [10:0] raw_inc;
   logic [9:0]  dec_next;

   assign is_digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign digit_diff = char_in - CH_ZERO;
   assign digit_val  = digit_diff[3:0];
   assign label_inc  = (cur.label_count == LABEL_SAT) ? cur.label_count
                                                      : cur.label_count + 7'd1;
   assign name_inc   = (cur.name_count == NAME_SAT) ? cur.name_count
                                                    : cur.name_count + 9'd1;
   assign raw_inc    = (cur.raw_count == RAW_SAT) ? cur.raw_count
                                                  : cur.raw_count + 11'd1;
   // value * 10 + digit, kept to 10 bits
   assign dec_next   = {cur.decimal_value[6:0], 3'b000}
                     + {cur.decimal_value[8:0], 1'b0}
                     + {6'd0, digit_val};

   assign bad = cur.error_seen
             || (cur.esc != ESC_NONE)
             || (cur.raw_count == 11'd0)
             || (cur.raw_count > RAW_LIMIT)
             || (cur.first_was_dot && (cur.raw_count != 11'd1))
             || (cur.name_count > NAME_LIMIT)
             || (cur.label_count > LABEL_LIMIT);

   always_comb begin
      nxt = cur;
      if (char_in == CH_END) begin
         nxt = DNV_CLEAR;
      end else begin
         nxt.raw_count = raw_inc;
         case (cur.esc)
            ESC_START: begin
               if (is_digit) begin
                  nxt.decimal_value = {6'd0, digit_val};
                  nxt.esc           = ESC_ONE;
               end else begin
                  nxt.label_count = label_inc;
                  nxt.name_count  = name_inc;
                  nxt.esc         = ESC_NONE;
               end
            end
            ESC_ONE: begin
               if (is_digit) begin
                  nxt.decimal_value = dec_next;
                  nxt.esc           = ESC_TWO;
               end else begin
                  nxt.error_seen    = 1'b1;
                  nxt.esc           = ESC_NONE;
                  nxt.decimal_value = 10'd0;
               end
            end
            ESC_TWO: begin
               if (is_digit) begin
                  if (dec_next > BYTE_MAX) begin
                     nxt.error_seen = 1'b1;
                  end
                  nxt.label_count = label_inc;
                  nxt.name_count  = name_inc;
               end else begin
                  nxt.error_seen = 1'b1;
               end
               nxt.esc           = ESC_NONE;
               nxt.decimal_value = 10'd0;
            end
            default: begin
               if (char_in == CH_DOT) begin
                  // A dot as the very first character may be the root name.
                  if ((cur.label_count == 7'd0) && (raw_inc == 11'd1)) begin
                     nxt.first_was_dot = 1'b1;
                  end else if ((cur.label_count == 7'd0)
                               || (cur.label_count > LABEL_LIMIT)) begin
                     nxt.error_seen = 1'b1;
                  end
                  nxt.label_count = 7'd0;
                  nxt.name_count  = name_inc;
               end else if (char_in == CH_BSL) begin
                  nxt.esc = ESC_START;
               end else begin
                  nxt.label_count = label_inc;
                  nxt.name_count  = name_inc;
               end
            end
         endcase
      end
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the domain name validator core.
// ----------------------------------------------------------------------------
// Names are fed one character per item. A model of the label, name and raw
// counters and of the escape sequencer predicts the verdict of every name.
// Each verdict that comes out is checked in order against that prediction.
// Both channels idle at random. One phase holds the result channel off while
// the block fills and stalls its input. Another lets the sender drain the
// block between groups of names.
module tb;
   import dnv_pkg::*;

   localparam int LABEL_LIMIT  = 63;
   localparam int NAME_LIMIT   = 255;
   localparam int IDLE_PCT     = 37;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_CHARS = 300;
   localparam int HOLD_CYCLES  = 300;

   typedef logic [7:0] text_type[$];

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_status;

   // Predicted checker state for the name in progress.
   logic [6:0]  lbl_octets;
   logic [8:0]  name_octets;
   logic [10:0] raw_chars;
   esc_type     esc_phase;
   logic [9:0]  esc_value;
   logic        sticky_err;
   logic        led_by_dot;

   logic pending_verdicts[$];

   bit idling  = 1'b1;
   bit holding = 1'b0;
   int mismatches    = 0;
   int chars_sent    = 0;
   int names_sent    = 0;
   int verdicts_seen = 0;
   int bad_seen      = 0;
   int stall_cycles  = 0;

   domain_name_validator_core #(
      .MAX_LABEL(LABEL_LIMIT),
      .MAX_NAME (NAME_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_char_in(req_char_in),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_name();
      lbl_octets  = '0;
      name_octets = '0;
      raw_chars   = '0;
      esc_phase   = ESC_NONE;
      esc_value   = '0;
      sticky_err  = 1'b0;
      led_by_dot  = 1'b0;
   endfunction

   function automatic void count_octet();
      if (lbl_octets < LABEL_SAT) lbl_octets++;
      if (name_octets < NAME_SAT) name_octets++;
   endfunction

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic void predict_verdict(input logic [7:0] ch);
      logic bad;
      int   digit;
      digit = int'(ch) - int'(CH_ZERO);
      if (ch == CH_END) begin
         bad = sticky_err || (esc_phase != ESC_NONE) || (raw_chars == 11'd0)
            || (int'(raw_chars) > 4 * NAME_LIMIT)
            || (led_by_dot && raw_chars != 11'd1)
            || (int'(name_octets) > NAME_LIMIT)
            || (int'(lbl_octets) > LABEL_LIMIT);
         pending_verdicts.push_back(bad);
         clear_name();
      end else begin
         if (raw_chars < RAW_SAT) raw_chars++;
         case (esc_phase)
            ESC_START: begin
               if (is_digit(ch)) begin
                  esc_value = 10'(digit);
                  esc_phase = ESC_ONE;
               end else begin
                  count_octet();
                  esc_phase = ESC_NONE;
               end
            end
            ESC_ONE, ESC_TWO: begin
               if (is_digit(ch)) begin
                  esc_value = 10'(int'(esc_value) * 10 + digit);
                  if (esc_phase == ESC_TWO) begin
                     if (esc_value > BYTE_MAX) sticky_err = 1'b1;
                     count_octet();
                     esc_phase = ESC_NONE;
                     esc_value = '0;
                  end else begin
                     esc_phase = ESC_TWO;
                  end
               end else begin
                  // A short numeric escape is dropped; the character counts as raw only.
                  sticky_err = 1'b1;
                  esc_phase  = ESC_NONE;
                  esc_value  = '0;
               end
            end
            default: begin
               if (ch == CH_DOT) begin
                  if (lbl_octets == 7'd0 && raw_chars == 11'd1) begin
                     led_by_dot = 1'b1;
                  end else if (lbl_octets == 7'd0 || int'(lbl_octets) > LABEL_LIMIT) begin
                     sticky_err = 1'b1;
                  end
                  lbl_octets = '0;
                  if (name_octets < NAME_SAT) name_octets++;
               end else if (ch == CH_BSL) begin
                  esc_phase = ESC_START;
               end else begin
                  count_octet();
               end
            end
         endcase
      end
   endfunction

   task automatic report_mismatch(input string what, input logic want, input logic got);
      $display("MISMATCH %s: expected %b got %b (verdict %0d)", what, want, got,
               verdicts_seen);
      mismatches++;
   endtask

   // Verdict checker.
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (rsp_status === 1'b1) bad_seen++;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with none pending", 1'bx, rsp_status);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want) report_mismatch("status", want, rsp_status);
         end
      end
   end

   // Result side: random stalls, a solid hold-off while holding is set, or always ready when not idling.
   always @(negedge clock) begin
      if (holding) begin
         rsp_ready <= 1'b0;
      end else if (idling) begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Entered and left at a falling edge; valid stays high for a following item.
   task automatic send_char(input logic [7:0] ch);
      if (idling) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid   = 1'b1;
      req_char_in = ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_verdict(ch);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_name(input text_type s);
      foreach (s[i]) send_char(s[i]);
      send_char(CH_END);
      names_sent++;
   endtask

   task automatic send_text(input string str);
      text_type s;
      for (int i = 0; i < str.len(); i++) s.push_back(str[i]);
      send_name(s);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      holding = 1'b1;
      repeat (cycles) @(negedge clock);
      holding = 1'b0;
   endtask

   task automatic add_run(inout text_type s, input logic [7:0] ch, input int n);
      repeat (n) s.push_back(ch);
   endtask

   task automatic add_escape(inout text_type s, input int v);
      s.push_back(CH_BSL);
      s.push_back(CH_ZERO + 8'((v / 100) % 10));
      s.push_back(CH_ZERO + 8'((v / 10) % 10));
      s.push_back(CH_ZERO + 8'(v % 10));
   endtask

   function automatic logic [7:0] label_char();
      string      host;
      logic [7:0] ch;
      host = "abcdefghijklmnopqrstuvwxyz0123456789-";
      if ($urandom_range(0, 9) == 0) begin
         ch = 8'($urandom_range(1, 255));
         if (ch == CH_DOT || ch == CH_BSL) ch = 8'hFF;
      end else begin
         ch = host[$urandom_range(0, host.len() - 1)];
      end
      return ch;
   endfunction

   function automatic logic [7:0] literal_char();
      logic [7:0] ch;
      case ($urandom_range(0, 3))
         0: ch = CH_DOT;
         1: ch = CH_BSL;
         default: begin
            ch = 8'($urandom_range(1, 255));
            if (is_digit(ch)) ch = "z";
         end
      endcase
      return ch;
   endfunction

   task automatic make_label(inout text_type s, input int len);
      int pick;
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            s.push_back(label_char());
         end else if (pick < 90) begin
            s.push_back(CH_BSL);
            s.push_back(literal_char());
         end else begin
            add_escape(s, $urandom_range(0, 255));
         end
      end
   endtask

   task automatic make_good_name(output text_type s);
      int labels;
      int len;
      s.delete();
      labels = $urandom_range(1, 4);
      for (int i = 0; i < labels; i++) begin
         if (i > 0) s.push_back(CH_DOT);
         // Now and then a label right around the length limit.
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
         make_label(s, len);
      end
      if ($urandom_range(0, 2) == 0) s.push_back(CH_DOT);
   endtask

   task automatic make_broken_name(output text_type s);
      int pos;
      make_good_name(s);
      case ($urandom_range(0, 7))
         0: s.delete();
         1: begin
            s.delete();
            s.push_back(CH_DOT);
         end
         2: s.push_front(CH_DOT);
         3: begin
            pos = $urandom_range(0, s.size());
            s.insert(pos, CH_DOT);
            s.insert(pos, CH_DOT);
         end
         4: begin
            s.push_back(CH_BSL);
            repeat ($urandom_range(1, 2)) s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            s.push_back("q");
            make_label(s, $urandom_range(0, 4));
         end
         5: begin
            add_escape(s, $urandom_range(256, 999));
            make_label(s, $urandom_range(0, 4));
         end
         6: s.push_back(CH_BSL);
         default: begin
            s.push_back(CH_BSL);
            repeat ($urandom_range(1, 2)) s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end
      endcase
   endtask

   task automatic make_noise(output text_type s);
      s.delete();
      repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(1, 255)));
   endtask

   task automatic test_directed();
      text_type s;
      send_text("");       // empty name
      send_text(".");      // the root alone
      send_text(".a");     // leading dot followed by more
      send_text("a..b");   // empty label
      send_text("\\1x");   // numeric escape cut short
      send_text("\\255");
      send_text("\\256");  // numeric escape above one byte
      send_text("a\\");    // escape still open at the end
      // Escaped dot and backslash, then the highest and lowest plain bytes.
      s.push_back(CH_BSL);
      s.push_back(CH_DOT);
      s.push_back(CH_BSL);
      s.push_back(CH_BSL);
      s.push_back(8'hFF);
      s.push_back(8'h01);
      send_name(s);
   endtask

   task automatic test_limits();
      text_type s;
      add_run(s, "a", LABEL_LIMIT);
      send_name(s);
      s.push_back("a");
      send_name(s);
   endtask

   task automatic test_drain();
      text_type s;
      repeat (2) begin
         repeat (3) begin
            make_good_name(s);
            send_name(s);
         end
         wait_drain();
      end
   endtask

   task automatic test_backpressure();
      wait_drain();
      idling = 1'b0;
      fork
         hold_receiver(HOLD_CYCLES);
         for (int n = 0; n < 20; n++) send_text("ab");
      join
      idling = 1'b1;
   endtask

   task automatic test_random();
      text_type s;
      int       start;
      int       pick;
      start = chars_sent;
      while (chars_sent - start < RANDOM_CHARS) begin
         // A stretch in the middle runs with neither side idling.
         idling = !((chars_sent - start) >= 100 && (chars_sent - start) < 200);
         if ($urandom_range(0, 24) == 0) wait_drain();
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            make_good_name(s);
         end else if (pick < 85) begin
            make_broken_name(s);
         end else begin
            make_noise(s);
         end
         send_name(s);
      end
      idling = 1'b1;
   endtask

   initial begin
      clear_name();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_limits();
      test_drain();
      test_backpressure();
      test_random();
      wait_drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d verdicts (%0d bad) over %0d names and %0d characters.",
               verdicts_seen, bad_seen, names_sent, chars_sent);
      $display("Run took in escapes, label length limits, random names and a full stall.");
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/dnv_pkg.sv
rtl/dnv_step.sv
rtl/domain_name_validator_core.sv
verif/tb.sv
